### sv/rom_dma_table_locator_unit_defines.svh
// Assertion macros shared by the locator RTL.
`ifndef ROM_DMA_TABLE_LOCATOR_UNIT_DEFINES_SVH
`define ROM_DMA_TABLE_LOCATOR_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define RDTL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RDTL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RDTL_ASSERT(lbl, clk, rst, prop, msg)
`define RDTL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### sv/rdtl_pkg.sv
package rdtl_pkg;

   localparam int WORD_W      = 32;
   localparam int POS_W       = 30;
   localparam int COUNT_W     = 28;
   localparam int WIN_DEPTH   = 11;
   localparam int ENTRY_SHIFT = 4;   // 16-byte entries

   // first window position that completes a twelve-word group
   localparam logic [POS_W-1:0] FIRST_CAND_POS = POS_W'(WIN_DEPTH);
   // a group ends on the last word of a 16-byte line
   localparam logic [1:0]       GROUP_END_PHASE = 2'd3;

   // register byte offsets (bit 2 of the address selects the register)
   localparam logic ADDR_IMG_BYTES = 1'b0;

   typedef enum logic {
      STATUS_FOUND = 1'b0,
      STATUS_NONE  = 1'b1
   } status_type;

   typedef logic [WIN_DEPTH-1:0][WORD_W-1:0] window_type;

   typedef struct packed {
      logic [WORD_W-1:0] rom_word;
      logic              last_word;
   } req_type;

   typedef struct packed {
      logic [0:0]         status;
      logic [WORD_W-1:0]  table_offset;
      logic [WORD_W-1:0]  table_bytes;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // search state handed from the window to the signature check
   typedef struct packed {
      window_type       window;
      logic [POS_W-1:0] position;
      logic             done;
   } search_type;

   typedef struct packed {
      logic              hit;
      logic [WORD_W-1:0] offset;
      logic [WORD_W-1:0] span;
   } match_type;

endpackage

### sv/rdtl_window.sv
`include "rom_dma_table_locator_unit_defines.svh"

module rdtl_window (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  rdtl_pkg::req_type               req,
   input  logic                            hit,
   output rdtl_pkg::search_type            search
);
   import rdtl_pkg::*;

   window_type       window_ff, window_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             done_ff, done_in;

   always_comb begin
      window_in = window_ff;
      pos_in    = pos_ff;
      done_in   = done_ff;
      if (accept) begin
         if (!done_ff) begin
            window_in = {req.rom_word, window_ff[WIN_DEPTH-1:1]};
            pos_in    = pos_ff + POS_W'(1);
            done_in   = hit;
         end
         if (req.last_word) begin
            pos_in  = '0;
            done_in = 1'b0;
         end
      end
   end

   // window words are only read once the position shows a full group
   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         done_ff <= done_in;
      end
   end

   assign search.window   = window_ff;
   assign search.position = pos_ff;
   assign search.done     = done_ff;

   `RDTL_ASSERT(a_pos_advance, clock, reset, accept && !done_ff && !req.last_word |=> pos_ff == $past(pos_ff) + POS_W'(1), "position did not advance")
   `RDTL_ASSERT(a_hit_sets_done, clock, reset, accept && hit && !req.last_word |=> done_ff, "match did not end the search")
   `RDTL_ASSERT(a_last_clears, clock, reset, accept && req.last_word |=> pos_ff == '0 && !done_ff, "end of image did not clear the search")
   `RDTL_ASSERT(a_done_frozen, clock, reset, done_ff && !(accept && req.last_word) |=> $stable(pos_ff) && done_ff, "search state moved after a match")

endmodule

### sv/rdtl_match.sv
module rdtl_match (
   input  rdtl_pkg::search_type            search,
   input  logic [rdtl_pkg::WORD_W-1:0]     word,
   input  logic [rdtl_pkg::WORD_W-1:0]     img_bytes,
   output rdtl_pkg::match_type             match
);
   import rdtl_pkg::*;

   logic [WORD_W-1:0] g [0:WIN_DEPTH];
   logic [POS_W-1:0]  pos_rel;
   logic [WORD_W-1:0] p;
   logic              cand;
   logic              e0_ok, e1_ok, e2_ok, end_ok;

   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         g[i] = search.window[i];
      end
      g[WIN_DEPTH] = word;
   end

   assign pos_rel = search.position - FIRST_CAND_POS;
   assign p       = {pos_rel, 2'b00};
   assign cand    = !search.done && (search.position >= FIRST_CAND_POS)
                    && (search.position[1:0] == GROUP_END_PHASE);

   assign e0_ok  = (g[0] == '0) && (g[1] != '0) && (g[2] == '0) && (g[3] == '0);
   assign e1_ok  = (g[4] == g[1]) && (g[6] == g[1]) && (g[7] == '0);
   assign e2_ok  = (g[8] == g[5]) && (g[10] == g[5]) && (g[11] == '0) && (g[8] == p);
   // span multiple of 16 <=> low nibbles agree
   assign end_ok = (g[9] <= img_bytes) && (g[9] > g[8])
                   && (g[9][ENTRY_SHIFT-1:0] == g[8][ENTRY_SHIFT-1:0]);

   assign match.hit    = cand && e0_ok && e1_ok && e2_ok && end_ok;
   assign match.offset = g[8];
   assign match.span   = g[9] - g[8];

endmodule

### sv/rom_dma_table_locator_unit.sv
// A result transfer is offered in the cycle after the word that causes it.
// Throughput: one image word per cycle; input stalls only while a finished
//   result sits in the output register and the result side is stalling.
// Reset (synchronous, active high): clears search position, match flag,
//   result valid and the image size register; the word window is not cleared.
`include "rom_dma_table_locator_unit_defines.svh"

module rom_dma_table_locator_unit (
   input  logic                            clock,
   input  logic                            reset,
   // image words
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rdtl_pkg::req_type               req_data,
   // results
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rdtl_pkg::rsp_type               rsp_data,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [2:0]                      csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import rdtl_pkg::*;

   logic [WORD_W-1:0] img_bytes_ff, img_bytes_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   search_type        search;
   match_type         match;
   logic              accept;
   logic              produce;
   logic              csr_write;

   // ---------------------------------------------------------------
   // Register port: single register, bit 2 of the address selects it.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == ADDR_IMG_BYTES);
   assign img_bytes_in = csr_write ? csr_pwdata : img_bytes_ff;
   assign csr_prdata   = (csr_paddr[2] == ADDR_IMG_BYTES) ? img_bytes_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_bytes_ff <= '0;
      end else begin
         img_bytes_ff <= img_bytes_in;
      end
   end

   // ---------------------------------------------------------------
   // Input transfer: taken whenever the output register is free or
   // being drained this cycle.
   // ---------------------------------------------------------------
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // Sliding window of the eleven previous words, position and match flag.
   rdtl_window u_window (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .hit    (match.hit),
      .search (search)
   );

   // Signature check over window plus the incoming word.
   rdtl_match u_match (
      .search    (search),
      .word      (req_data.rom_word),
      .img_bytes (img_bytes_ff),
      .match     (match)
   );

   // ---------------------------------------------------------------
   // Result register. Found wins over not-found on the last word;
   // after a match nothing more comes out until the next image.
   // ---------------------------------------------------------------
   assign produce = accept && !search.done && (match.hit || req_data.last_word);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (produce) begin
         if (match.hit) begin
            rsp_data_in.status       = STATUS_FOUND;
            rsp_data_in.table_offset = match.offset;
            rsp_data_in.table_bytes  = match.span;
            rsp_data_in.entry_count  = match.span[WORD_W-1:ENTRY_SHIFT];
         end else begin
            rsp_data_in.status       = STATUS_NONE;
            rsp_data_in.table_offset = '0;
            rsp_data_in.table_bytes  = '0;
            rsp_data_in.entry_count  = '0;
         end
      end
   end

   assign rsp_valid_in = produce || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RDTL_ASSERT(a_no_overwrite, clock, reset, produce |-> !(rsp_valid_ff && rsp_stall), "pending result overwritten")
   `RDTL_ASSERT(a_found_aligned, clock, reset, rsp_valid_ff && rsp_data_ff.status == STATUS_FOUND |-> rsp_data_ff.table_offset[ENTRY_SHIFT-1:0] == '0 && rsp_data_ff.table_bytes[ENTRY_SHIFT-1:0] == '0 && rsp_data_ff.table_bytes != '0, "found table not on entry boundaries")
   `RDTL_ASSERT(a_count_matches, clock, reset, rsp_valid_ff |-> rsp_data_ff.entry_count == rsp_data_ff.table_bytes[WORD_W-1:ENTRY_SHIFT], "entry count disagrees with size")
   `RDTL_ASSERT(a_none_zero, clock, reset, rsp_valid_ff && rsp_data_ff.status == STATUS_NONE |-> rsp_data_ff.table_offset == '0 && rsp_data_ff.table_bytes == '0, "not-found result carries data")
   `RDTL_ASSERT_ALWAYS(a_ready_high, clock, csr_pready, "register port not ready")

endmodule

### dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rdtl_pkg::*;

   // register map: one 32-bit register, byte address 4*index
   localparam int IMG_BYTES_REG  = 0;
   localparam int IDLE_PCT       = 28;
   localparam int BACKLOG_CYCLES = 400;
   // result is offered in the cycle after its word; leave a little margin
   localparam int SETTLE_CYCLES  = 8;

   // ways a planted directory signature can be spoiled
   typedef enum int {
      SIG_CLEAN,
      SIG_LEAD_WORD,      // first entry virtual start nonzero
      SIG_ZERO_END,       // first entry virtual end zero
      SIG_PHYS_END,       // a physical end word nonzero
      SIG_BROKEN_CHAIN,   // a start does not match the previous end
      SIG_WRONG_OFFSET,   // third entry start is not the signature position
      SIG_PAST_ROM,       // table end beyond the image size
      SIG_EMPTY_SPAN,     // table end not above table start
      SIG_ODD_SPAN        // span not a whole number of entries
   } sig_flaw_type;

   typedef struct packed {
      req_type item;
      bit      drain;     // hold this transfer until all results are back
   } word_slot_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rom_dma_table_locator_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Scan predictor: own copy of the search state and of the image size
   // ---------------------------------------------------------------
   logic [31:0] scan_window [WIN_DEPTH];
   logic [29:0] scan_pos;
   bit          dir_found;
   logic [31:0] rom_limit;

   word_slot_type pend_words[$];    // image words not yet offered
   rsp_type     table_reports[$];   // locator results still owed
   logic [31:0] img_words[$];       // image under construction
   int          mismatches = 0;
   bit          calm = 1'b0;        // no random idling on either side
   int          backlog_req = 0;    // bump to make the receiver hold off

   initial begin
      rom_limit = '0;
      dir_found = 1'b0;
      scan_pos  = '0;
      foreach (scan_window[i]) scan_window[i] = '0;
   end

   // Consumes one image word. Returns 1 with the result when the word
   // completes a signature or ends an image that had none.
   function automatic bit locate_step(input req_type w, output rsp_type r);
      logic [31:0] g [12];
      logic [31:0] p;
      logic [31:0] span;
      bit          hit;
      bit          emit;
      r    = '0;
      hit  = 1'b0;
      emit = 1'b0;
      if (!dir_found) begin
         // a group closes on the last word of each aligned 16-byte line
         if (scan_pos >= 30'(WIN_DEPTH) && scan_pos[1:0] == 2'd3) begin
            for (int i = 0; i < WIN_DEPTH; i++) g[i] = scan_window[i];
            g[11] = w.rom_word;
            p     = {scan_pos - 30'(WIN_DEPTH), 2'b00};
            span  = g[9] - g[8];
            hit = g[0] == 0 && g[1] != 0 && g[2] == 0 && g[3] == 0 &&
                  g[4] == g[1] && g[6] == g[1] && g[7] == 0 &&
                  g[8] == g[5] && g[10] == g[5] && g[11] == 0 && g[8] == p &&
                  g[9] <= rom_limit && g[9] > g[8] && span[3:0] == 4'd0;
            if (hit) begin
               r.status       = STATUS_FOUND;
               r.table_offset = g[8];
               r.table_bytes  = span;
               r.entry_count  = span[31:4];
               dir_found      = 1'b1;
               emit           = 1'b1;
            end
         end
         if (!hit && w.last_word) begin
            r.status = STATUS_NONE;
            emit     = 1'b1;
         end
         for (int i = 0; i < WIN_DEPTH - 1; i++) scan_window[i] = scan_window[i+1];
         scan_window[WIN_DEPTH-1] = w.rom_word;
         scan_pos = scan_pos + 30'd1;
      end
      if (w.last_word) begin
         foreach (scan_window[i]) scan_window[i] = '0;
         scan_pos  = '0;
         dir_found = 1'b0;
      end
      return emit;
   endfunction

   // ---------------------------------------------------------------
   // Word driver: offers queued words, predicts on each transfer
   // ---------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      word_slot_type nxt;
      rsp_type    rpt;
      bit         go;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall && locate_step(req_data, rpt))
            table_reports.push_back(rpt);
         // a stalled word stays put; otherwise pick the next one or idle
         if (!(req_valid && req_stall)) begin
            go = pend_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT);
            if (go && pend_words[0].drain && table_reports.size() != 0)
               go = 1'b0;
            if (go) begin
               nxt = pend_words.pop_front();
               req_data  <= nxt.item;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Result monitor: checks each transfer, drives random stall
   // ---------------------------------------------------------------
   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
         mismatches++;
      end
   endtask

   int backlog_seen = 0;
   int hold_left    = 0;

   always @(posedge clock) begin : rsp_monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (table_reports.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %h",
                        $time, rsp_data);
               mismatches++;
            end else begin
               want = table_reports.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("table_offset", want.table_offset, rsp_data.table_offset);
               check_field("table_bytes", want.table_bytes, rsp_data.table_bytes);
               check_field("entry_count", 32'(want.entry_count), 32'(rsp_data.entry_count));
            end
         end
         // long hold-off so the result register fills and the input stalls
         if (backlog_req != backlog_seen) begin
            backlog_seen = backlog_req;
            hold_left    = BACKLOG_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && $urandom_range(99) < IDLE_PCT;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic wait_idle();
      while (pend_words.size() != 0 || req_valid || table_reports.size() != 0)
         @(posedge clock);
   endtask

   // register writes only with the block quiet
   task automatic csr_write(input logic [31:0] value);
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_paddr   <= 3'(4 * IMG_BYTES_REG);
      csr_pwdata  <= value;
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rom_limit   = value;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [31:0] noise_word();
      case ($urandom_range(3))
         0:       return 32'h0;
         1:       return 32'(16 * $urandom_range(255));
         default: return $urandom;
      endcase
   endfunction

   task automatic add_noise(input int n);
      for (int i = 0; i < n; i++) img_words.push_back(noise_word());
   endtask

   // Appends a twelve-word signature at the current image position.
   task automatic add_table(input sig_flaw_type flaw);
      logic [31:0]     g [12];
      logic [31:0]     p;
      logic [31:0]     v1;
      logic [31:0]     dir_end;
      longint unsigned lim;
      longint unsigned top_k;
      longint unsigned k;
      longint unsigned past;
      p   = 32'(img_words.size() * 4);
      lim = rom_limit;
      v1  = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
      if (v1 == 0) v1 = 32'h1;
      top_k = (lim >= longint'(p) + 16) ? (lim - p) / 16 : 1;
      case ($urandom_range(3))
         0:       k = 1;
         1:       k = top_k;     // end lands on (or just under) the image size
         default: k = 1 + ($urandom % top_k);
      endcase
      dir_end = 32'(longint'(p) + 16 * k);
      g = '{32'h0, v1, 32'h0, 32'h0, v1, p, v1, 32'h0, p, dir_end, p, 32'h0};
      case (flaw)
         SIG_LEAD_WORD: g[0] = $urandom | 32'h1;
         SIG_ZERO_END: begin
            g[1] = '0;
            g[4] = '0;
            g[6] = '0;
         end
         SIG_PHYS_END: begin
            case ($urandom_range(3))
               0:       g[2]  = 32'h1 << $urandom_range(31);
               1:       g[3]  = 32'h1 << $urandom_range(31);
               2:       g[7]  = 32'h1 << $urandom_range(31);
               default: g[11] = 32'h1 << $urandom_range(31);
            endcase
         end
         SIG_BROKEN_CHAIN: begin
            case ($urandom_range(2))
               0:       g[4]  ^= 32'h1 << $urandom_range(31);
               1:       g[6]  ^= 32'h1 << $urandom_range(31);
               default: g[10] ^= 32'h1 << $urandom_range(31);
            endcase
         end
         SIG_WRONG_OFFSET: begin
            g[5]  = p ^ (32'h10 << $urandom_range(27));
            g[8]  = g[5];
            g[10] = g[5];
         end
         SIG_PAST_ROM: begin
            past = longint'(p) +
                   16 * (((lim >= longint'(p) + 16) ? (lim - p) / 16 : 0) + 1);
            g[9] = (past <= 64'hFFFF_FFFF) ? 32'(past) : p;
         end
         SIG_EMPTY_SPAN: g[9] = p - 32'(16 * $urandom_range(0, 2));
         SIG_ODD_SPAN:   g[9] = dir_end - 32'($urandom_range(1, 15));
         default: ;
      endcase
      for (int i = 0; i < 12; i++) img_words.push_back(g[i]);
   endtask

   // Queues the built image; last_word rides on its final word.
   task automatic ship_image(input bit drain);
      word_slot_type s;
      for (int i = 0; i < img_words.size(); i++) begin
         s.item.rom_word  = img_words[i];
         s.item.last_word = (i == img_words.size() - 1);
         s.drain          = drain && i == 0;
         pend_words.push_back(s);
      end
      img_words.delete();
   endtask

   task automatic make_image(input bit drain);
      int kind;
      int cut;
      kind = $urandom_range(99);
      img_words.delete();
      add_noise(4 * $urandom_range(0, 6));
      if (kind < 55) begin
         add_table(SIG_CLEAN);
      end else if (kind < 75) begin
         // near miss, sometimes followed by a real table further on
         add_table(sig_flaw_type'($urandom_range(1, 8)));
         if ($urandom_range(1)) add_table(SIG_CLEAN);
      end else if (kind < 85) begin
         // valid signature off the 16-byte grid
         add_noise($urandom_range(1, 3));
         add_table(SIG_CLEAN);
      end else if (kind < 93) begin
         // image ends inside the signature group
         add_table(SIG_CLEAN);
         cut = $urandom_range(1, 11);
         for (int i = 0; i < cut; i++) void'(img_words.pop_back());
      end else begin
         add_noise($urandom_range(1, 40));
      end
      // words after a match are ignored until the last one
      if (kind < 85 && $urandom_range(2) == 0) add_noise($urandom_range(1, 12));
      if (img_words.size() == 0) add_noise(1);
      ship_image(drain);
   endtask

   task automatic random_phase(input int n_words, input bit backlog);
      int queued;
      int imgs;
      queued = pend_words.size();
      imgs   = 0;
      while (pend_words.size() - queued < n_words) begin
         make_image(imgs == 3 || $urandom_range(7) == 0);
         imgs++;
      end
      if (backlog) backlog_req++;
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      csr_write(32'hFFFF_FFFF);

      // table at offset 0 completed by the last word, largest span
      img_words = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0,
                    32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
                    32'h0, 32'hFFFF_FFF0, 32'h0, 32'h0};
      ship_image(1'b0);
      // short image, no candidate at all
      img_words = '{32'hFFFF_FFFF, 32'h0, 32'h5A5A_A5A5};
      ship_image(1'b0);
      // one-entry table, then trailing words that must be ignored
      img_words = '{32'h0, 32'h1, 32'h0, 32'h0,
                    32'h1, 32'h0, 32'h1, 32'h0,
                    32'h0, 32'h10, 32'h0, 32'h0,
                    32'hFFFF_FFFF, 32'h1234_5678};
      ship_image(1'b0);

      random_phase(250, 1'b0);

      csr_write(32'h0);            // nothing can fit
      random_phase(200, 1'b0);

      csr_write(32'h0000_0400);
      calm = 1'b1;                 // full-rate stretch on both sides
      random_phase(250, 1'b0);
      wait_idle();
      calm = 1'b0;

      csr_write(32'h0000_0100);
      random_phase(250, 1'b1);

      csr_write($urandom);
      random_phase(250, 1'b0);

      csr_write(32'h0001_0000);
      random_phase(250, 1'b1);

      csr_write(32'hFFFF_FFFF);
      random_phase(300, 1'b0);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // run limit, far above the slowest legal run
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
